### design/vld_pkg.sv
// Package for the varint length deframer: shared constants and types.
// Used by vld_header_step, vld_flow_core and varint_length_deframer.
`timescale 1ns / 1ps
`default_nettype none

package vld_pkg;

    // Default parameter values.
    localparam int FLOW_SLOTS_DEF    = 4;
    localparam int PREFIX_MAX_DEF    = 5;

    // Fixed widths of the stream fields.
    localparam int SLOT_IN_W         = 2;
    localparam int VALUE_W           = 31;
    localparam int COUNT_W           = 32;
    localparam int PAYLOAD_W         = 7;
    localparam int SHIFTED_W         = 36;

    // The length prefix counts these extra bytes beyond the body.
    localparam int LENGTH_BIAS       = 4;

    // Prefix bytes whose payload still lands below bit 31.
    localparam int PAYLOAD_BYTES     = 5;

    // Per-slot framing phase.
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_BODY    = 2'd1,
        PH_DISCARD = 2'd2
    } t_phase;

    // Outcome of one header byte.
    typedef struct packed {
        logic                malformed;
        logic                done;
        logic [VALUE_W-1:0]  accum;
        logic [VALUE_W-1:0]  total;
    } t_hdr_out;

    // Result of one step, without the pass-through fields.
    typedef struct packed {
        logic                valid;
        logic [VALUE_W-1:0]  frame_length;
        logic                first_of_frame;
        logic                last_of_frame;
        logic [COUNT_W-1:0]  malformed_total;
    } t_step_out;

endpackage

`default_nettype wire

### design/vld_header_step.sv
// Combinational update of the varint length prefix for one header byte.
// Depends on vld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vld_header_step #(
    parameter int PREFIX_MAX_BYTES = vld_pkg::PREFIX_MAX_DEF,
    parameter int PB_W             = $clog2(PREFIX_MAX_BYTES + 1)
) (
    input  wire logic [vld_pkg::VALUE_W-1:0] i_accum,
    input  wire logic [PB_W-1:0]             i_prefix_bytes,
    input  wire logic [7:0]                  i_data_byte,
    output vld_pkg::t_hdr_out                o_hdr,
    output logic      [PB_W-1:0]             o_prefix_bytes
);

    logic [3:0]                      pb_x;
    logic [vld_pkg::PAYLOAD_W-1:0]   payload;
    logic [vld_pkg::SHIFTED_W-1:0]   shifted;
    logic [vld_pkg::SHIFTED_W-1:0]   sum;
    logic                            beyond;
    logic                            overflow;
    logic                            cont;
    logic                            too_long;
    logic                            too_short;
    logic [vld_pkg::VALUE_W-1:0]     value;

    assign pb_x    = 4'(i_prefix_bytes);
    assign payload = i_data_byte[vld_pkg::PAYLOAD_W-1:0];
    assign cont    = i_data_byte[7];

    // Place the seven payload bits at their position in the value.
    always_comb begin
        case (pb_x)
            4'd0:    shifted = vld_pkg::SHIFTED_W'(payload);
            4'd1:    shifted = vld_pkg::SHIFTED_W'(payload) << 7;
            4'd2:    shifted = vld_pkg::SHIFTED_W'(payload) << 14;
            4'd3:    shifted = vld_pkg::SHIFTED_W'(payload) << 21;
            4'd4:    shifted = vld_pkg::SHIFTED_W'(payload) << 28;
            default: shifted = '0;
        endcase
    end

    // Bytes past the fifth may only carry zero payload bits.
    assign beyond   = (pb_x >= 4'(vld_pkg::PAYLOAD_BYTES));
    assign sum      = vld_pkg::SHIFTED_W'(i_accum) + shifted;
    assign overflow = beyond ? (payload != '0)
                             : (sum[vld_pkg::SHIFTED_W-1:vld_pkg::VALUE_W] != '0);
    assign value    = beyond ? i_accum : sum[vld_pkg::VALUE_W-1:0];

    assign o_prefix_bytes = i_prefix_bytes + PB_W'(1);

    // A continued prefix that reaches the byte limit, or a final value
    // that leaves no body, makes the frame malformed.
    assign too_long  = cont && (o_prefix_bytes >= PB_W'(PREFIX_MAX_BYTES));
    assign too_short = !cont && (value <= vld_pkg::VALUE_W'(vld_pkg::LENGTH_BIAS));

    assign o_hdr.malformed = overflow || too_long || too_short;
    assign o_hdr.done      = !cont && !overflow && !too_short;
    assign o_hdr.accum     = value;
    assign o_hdr.total     = value - vld_pkg::VALUE_W'(vld_pkg::LENGTH_BIAS);

endmodule

`default_nettype wire

### design/vld_flow_core.sv
// Per-slot framing state, the malformed counter and the body byte logic.
// Depends on vld_pkg and vld_header_step.
`timescale 1ns / 1ps
`default_nettype none

module vld_flow_core #(
    parameter int FLOW_SLOTS       = vld_pkg::FLOW_SLOTS_DEF,
    parameter int PREFIX_MAX_BYTES = vld_pkg::PREFIX_MAX_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_fire,
    input  wire logic                            i_command,
    input  wire logic [vld_pkg::SLOT_IN_W-1:0]   i_flow_slot,
    input  wire logic [7:0]                      i_data_byte,
    input  wire logic                            i_chunk_end,
    output vld_pkg::t_step_out                   o_res
);

    localparam int SLOT_W = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
    localparam int WIDE_W = SLOT_W + vld_pkg::SLOT_IN_W;
    localparam int PB_W   = $clog2(PREFIX_MAX_BYTES + 1);
    localparam int VW     = vld_pkg::VALUE_W;

    vld_pkg::t_phase          r_phase [FLOW_SLOTS];
    logic [VW-1:0]            r_accum [FLOW_SLOTS];
    logic [PB_W-1:0]          r_pb    [FLOW_SLOTS];
    logic [VW-1:0]            r_left  [FLOW_SLOTS];
    logic [VW-1:0]            r_total [FLOW_SLOTS];
    logic [vld_pkg::COUNT_W-1:0] r_malformed;

    vld_pkg::t_phase          n_phase;
    logic [VW-1:0]            n_accum;
    logic [PB_W-1:0]          n_pb;
    logic [VW-1:0]            n_left;
    logic [VW-1:0]            n_total;
    logic [vld_pkg::COUNT_W-1:0] n_malformed;

    logic [WIDE_W-1:0]        slot_wide;
    logic [SLOT_W-1:0]        idx;
    logic                     in_range;
    logic                     write_en;
    vld_pkg::t_phase          cur_phase;
    logic [VW-1:0]            cur_left;
    logic [VW-1:0]            cur_total;
    vld_pkg::t_hdr_out        hdr;
    logic [PB_W-1:0]          hdr_pb;
    logic                     body_last;

    // Slot decode: slots past the configured count are ignored.
    assign slot_wide = {SLOT_W'(0), i_flow_slot};
    assign idx       = slot_wide[SLOT_W-1:0];
    assign in_range  = (slot_wide < WIDE_W'(FLOW_SLOTS));
    assign write_en  = i_fire && in_range;

    assign cur_phase = r_phase[idx];
    assign cur_left  = r_left[idx];
    assign cur_total = r_total[idx];
    assign body_last = (cur_left <= VW'(1));

    vld_header_step #(
        .PREFIX_MAX_BYTES (PREFIX_MAX_BYTES),
        .PB_W             (PB_W)
    ) u_header_step (
        .i_accum        (r_accum[idx]),
        .i_prefix_bytes (r_pb[idx]),
        .i_data_byte    (i_data_byte),
        .o_hdr          (hdr),
        .o_prefix_bytes (hdr_pb)
    );

    // Next state of the addressed slot and of the counter.
    always_comb begin
        n_phase     = cur_phase;
        n_accum     = r_accum[idx];
        n_pb        = r_pb[idx];
        n_left      = cur_left;
        n_total     = cur_total;
        n_malformed = r_malformed;
        if (i_command) begin
            n_phase = vld_pkg::PH_HEADER;
            n_accum = '0;
            n_pb    = '0;
            n_left  = '0;
            n_total = '0;
        end else begin
            unique case (cur_phase)
                vld_pkg::PH_DISCARD: begin
                    if (i_chunk_end) begin
                        n_phase = vld_pkg::PH_HEADER;
                    end
                end
                vld_pkg::PH_BODY: begin
                    if (body_last) begin
                        n_phase = vld_pkg::PH_HEADER;
                        n_accum = '0;
                        n_pb    = '0;
                        n_left  = '0;
                        n_total = '0;
                    end else begin
                        n_left = cur_left - VW'(1);
                    end
                end
                default: begin
                    if (hdr.malformed) begin
                        if (r_malformed != '1) begin
                            n_malformed = r_malformed + vld_pkg::COUNT_W'(1);
                        end
                        n_phase = i_chunk_end ? vld_pkg::PH_HEADER : vld_pkg::PH_DISCARD;
                        n_accum = '0;
                        n_pb    = '0;
                        n_left  = '0;
                        n_total = '0;
                    end else if (hdr.done) begin
                        n_phase = vld_pkg::PH_BODY;
                        n_accum = '0;
                        n_pb    = '0;
                        n_left  = hdr.total;
                        n_total = hdr.total;
                    end else begin
                        n_accum = hdr.accum;
                        n_pb    = hdr_pb;
                    end
                end
            endcase
        end
    end

    // Slot state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < FLOW_SLOTS; s++) begin
                r_phase[s] <= vld_pkg::PH_HEADER;
                r_accum[s] <= '0;
                r_pb[s]    <= '0;
                r_left[s]  <= '0;
                r_total[s] <= '0;
            end
            r_malformed <= '0;
        end else if (write_en) begin
            r_phase[idx] <= n_phase;
            r_accum[idx] <= n_accum;
            r_pb[idx]    <= n_pb;
            r_left[idx]  <= n_left;
            r_total[idx] <= n_total;
            r_malformed  <= n_malformed;
        end
    end

    // A body byte produces one result.
    assign o_res.valid           = write_en && !i_command && (cur_phase == vld_pkg::PH_BODY);
    assign o_res.frame_length    = cur_total;
    assign o_res.first_of_frame  = (cur_left == cur_total);
    assign o_res.last_of_frame   = body_last;
    assign o_res.malformed_total = r_malformed;

endmodule

`default_nettype wire

### design/varint_length_deframer.sv
// Varint length prefixed deframer: input register, framing core, result register.
// A request is held in the input register; its result is held in the result register.
// Throughput: one request per cycle on any mix of slots, unless the result register
// is full and stalled; the per-slot state is read and written between the two registers.
// Reset (synchronous, active low) puts every slot in the header phase with
// cleared length state, zeroes the malformed counter and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module varint_length_deframer #(
    parameter int FLOW_SLOTS       = vld_pkg::FLOW_SLOTS_DEF,
    parameter int PREFIX_MAX_BYTES = vld_pkg::PREFIX_MAX_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic                           i_command,
    input  wire logic [vld_pkg::SLOT_IN_W-1:0]  i_flow_slot,
    input  wire logic [63:0]                    i_flow_tag,
    input  wire logic [31:0]                    i_source_address,
    input  wire logic signed [63:0]             i_time_stamp,
    input  wire logic [7:0]                     i_data_byte,
    input  wire logic                           i_chunk_end,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [63:0]                         o_out_flow_tag,
    output logic [31:0]                         o_out_source,
    output logic signed [63:0]                  o_out_time,
    output logic [7:0]                          o_body_byte,
    output logic [vld_pkg::VALUE_W-1:0]         o_frame_length,
    output logic                                o_first_of_frame,
    output logic                                o_last_of_frame,
    output logic [vld_pkg::COUNT_W-1:0]         o_malformed_total
);

    logic                                r_in_valid;
    logic                                r_command;
    logic [vld_pkg::SLOT_IN_W-1:0]       r_flow_slot;
    logic [63:0]                         r_flow_tag;
    logic [31:0]                         r_source;
    logic signed [63:0]                  r_time;
    logic [7:0]                          r_data_byte;
    logic                                r_chunk_end;

    logic                                r_out_valid;
    logic [63:0]                         r_out_flow_tag;
    logic [31:0]                         r_out_source;
    logic signed [63:0]                  r_out_time;
    logic [7:0]                          r_out_byte;
    logic [vld_pkg::VALUE_W-1:0]         r_out_length;
    logic                                r_out_first;
    logic                                r_out_last;
    logic [vld_pkg::COUNT_W-1:0]         r_out_malformed;

    logic                                fire;
    logic                                in_take;
    vld_pkg::t_step_out                  res;

    // The held request moves on when the result register can take its result.
    assign fire    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !fire;
    assign in_take = i_valid && !o_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_command   <= i_command;
            r_flow_slot <= i_flow_slot;
            r_flow_tag  <= i_flow_tag;
            r_source    <= i_source_address;
            r_time      <= i_time_stamp;
            r_data_byte <= i_data_byte;
            r_chunk_end <= i_chunk_end;
        end
    end

    vld_flow_core #(
        .FLOW_SLOTS       (FLOW_SLOTS),
        .PREFIX_MAX_BYTES (PREFIX_MAX_BYTES)
    ) u_flow_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_command   (r_command),
        .i_flow_slot (r_flow_slot),
        .i_data_byte (r_data_byte),
        .i_chunk_end (r_chunk_end),
        .o_res       (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= res.valid;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res.valid) begin
            r_out_flow_tag  <= r_flow_tag;
            r_out_source    <= r_source;
            r_out_time      <= r_time;
            r_out_byte      <= r_data_byte;
            r_out_length    <= res.frame_length;
            r_out_first     <= res.first_of_frame;
            r_out_last      <= res.last_of_frame;
            r_out_malformed <= res.malformed_total;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_out_flow_tag    = r_out_flow_tag;
    assign o_out_source      = r_out_source;
    assign o_out_time        = r_out_time;
    assign o_body_byte       = r_out_byte;
    assign o_frame_length    = r_out_length;
    assign o_first_of_frame  = r_out_first;
    assign o_last_of_frame   = r_out_last;
    assign o_malformed_total = r_out_malformed;

endmodule

`default_nettype wire

### test/tb_top.sv
// Testbench for varint_length_deframer: directed and random requests on all flow slots,
// a behavioral deframer that predicts every body byte, and a field-by-field result check.
// Depends on vld_pkg (design/vld_pkg.sv) and the varint_length_deframer RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int NSLOT = vld_pkg::FLOW_SLOTS_DEF;
    localparam int PREFIX_MAX = vld_pkg::PREFIX_MAX_DEF;
    localparam logic [31:0] MAX_LENGTH = (32'd1 << vld_pkg::VALUE_W) - 1;
    localparam int RANDOM_REQUESTS = 1800;
    localparam int PRESSURE_CYCLES = 200;
    localparam int PRESSURE_AFTER = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int DRAIN_LIMIT = 5000;
    localparam int CYCLE_LIMIT = 1000000;

    // How the pass-through fields of a request are filled.
    localparam int PASS_RANDOM = 0;
    localparam int PASS_HIGH = 1;
    localparam int PASS_LOW = 2;

    typedef struct {
        logic               command;
        logic [1:0]         flow_slot;
        logic [63:0]        flow_tag;
        logic [31:0]        source_address;
        logic signed [63:0] time_stamp;
        logic [7:0]         data_byte;
        logic               chunk_end;
    } t_request;

    typedef struct {
        logic [63:0]        flow_tag;
        logic [31:0]        source;
        logic signed [63:0] time_stamp;
        logic [7:0]         body_byte;
        logic [30:0]        frame_length;
        logic               first_mark;
        logic               last_mark;
        logic [31:0]        malformed_total;
    } t_body_byte;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_command = 1'b0;
    logic [1:0]         i_flow_slot = '0;
    logic [63:0]        i_flow_tag = '0;
    logic [31:0]        i_source_address = '0;
    logic signed [63:0] i_time_stamp = '0;
    logic [7:0]         i_data_byte = '0;
    logic               i_chunk_end = 1'b0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [63:0]        o_out_flow_tag;
    logic [31:0]        o_out_source;
    logic signed [63:0] o_out_time;
    logic [7:0]         o_body_byte;
    logic [30:0]        o_frame_length;
    logic               o_first_of_frame;
    logic               o_last_of_frame;
    logic [31:0]        o_malformed_total;

    t_request   pending_requests[$];
    t_body_byte expected_bytes[$];
    t_request   offered_request;

    // Deframer state as the testbench sees it, one entry per flow slot.
    vld_pkg::t_phase slot_phase [NSLOT];
    logic [31:0] slot_accum [NSLOT];
    int          slot_prefix [NSLOT];
    logic [30:0] slot_left [NSLOT];
    logic [30:0] slot_total [NSLOT];
    logic [31:0] malformed_seen = '0;

    // Stimulus plan per slot: header bytes still to send, body bytes, trailing slot reset.
    logic [7:0] plan_hdr [NSLOT][10];
    logic       plan_ce [NSLOT][10];
    int         plan_len [NSLOT];
    int         plan_pos [NSLOT];
    int         plan_body [NSLOT];
    bit         plan_cut [NSLOT];

    int error_count = 0;
    int accepted_count = 0;
    int bytes_checked = 0;
    int frames_closed = 0;
    int send_gap = 0;
    int stall_left = 0;
    bit pressure_done = 1'b0;
    int cycle_count = 0;

    varint_length_deframer u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_command         (i_command),
        .i_flow_slot       (i_flow_slot),
        .i_flow_tag        (i_flow_tag),
        .i_source_address  (i_source_address),
        .i_time_stamp      (i_time_stamp),
        .i_data_byte       (i_data_byte),
        .i_chunk_end       (i_chunk_end),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_out_flow_tag    (o_out_flow_tag),
        .o_out_source      (o_out_source),
        .o_out_time        (o_out_time),
        .o_body_byte       (o_body_byte),
        .o_frame_length    (o_frame_length),
        .o_first_of_frame  (o_first_of_frame),
        .o_last_of_frame   (o_last_of_frame),
        .o_malformed_total (o_malformed_total)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    task automatic clear_slot(input int s);
        slot_phase[s] = vld_pkg::PH_HEADER;
        slot_accum[s] = '0;
        slot_prefix[s] = 0;
        slot_left[s] = '0;
        slot_total[s] = '0;
    endtask

    // Advances the slot state for one accepted request and queues the body byte it yields.
    task automatic deframe_request(input t_request req);
        int          s;
        int          shift;
        logic [63:0] value;
        logic [6:0]  payload;
        bit          bad;
        t_body_byte  res;
        s = req.flow_slot;
        if (req.command) begin
            clear_slot(s);
            return;
        end
        // Discard runs until the chunk ends.
        if (slot_phase[s] == vld_pkg::PH_DISCARD) begin
            if (req.chunk_end) slot_phase[s] = vld_pkg::PH_HEADER;
            return;
        end
        // Body bytes pass out with the frame marks.
        if (slot_phase[s] == vld_pkg::PH_BODY) begin
            res.flow_tag = req.flow_tag;
            res.source = req.source_address;
            res.time_stamp = req.time_stamp;
            res.body_byte = req.data_byte;
            res.frame_length = slot_total[s];
            res.first_mark = (slot_left[s] == slot_total[s]);
            res.last_mark = (slot_left[s] <= 1);
            res.malformed_total = malformed_seen;
            expected_bytes.push_back(res);
            if (slot_left[s] <= 1) clear_slot(s);
            else slot_left[s] = 31'(slot_left[s] - 1);
            return;
        end
        // Header phase: extend the varint; any phase other than body or discard lands here.
        payload = req.data_byte[6:0];
        shift = 7 * slot_prefix[s];
        value = {32'd0, slot_accum[s]};
        bad = 1'b0;
        if (shift >= vld_pkg::VALUE_W) begin
            bad = (payload != 0);
        end else begin
            value = value + ({57'd0, payload} << shift);
            bad = (value > MAX_LENGTH);
        end
        if (!bad) begin
            slot_accum[s] = value[31:0];
            slot_prefix[s] = slot_prefix[s] + 1;
            if (req.data_byte[7]) begin
                bad = (slot_prefix[s] >= PREFIX_MAX);
            end else if (value <= vld_pkg::LENGTH_BIAS) begin
                bad = 1'b1;
            end else begin
                slot_total[s] = 31'(value[30:0] - vld_pkg::LENGTH_BIAS);
                slot_left[s] = slot_total[s];
                slot_accum[s] = '0;
                slot_prefix[s] = 0;
                slot_phase[s] = vld_pkg::PH_BODY;
            end
        end
        // A malformed prefix counts once; the rest of the chunk is dropped.
        if (bad) begin
            if (malformed_seen != '1) malformed_seen = malformed_seen + 1;
            clear_slot(s);
            if (!req.chunk_end) slot_phase[s] = vld_pkg::PH_DISCARD;
        end
    endtask

    task automatic push_request(input logic cmd, input int s, input logic [7:0] b,
                                input logic ce, input int pass_kind);
        t_request req;
        req.command = cmd;
        req.flow_slot = s[1:0];
        req.data_byte = b;
        req.chunk_end = ce;
        case (pass_kind)
            PASS_HIGH: begin
                req.flow_tag = '1;
                req.source_address = '1;
                req.time_stamp = 64'sh7FFF_FFFF_FFFF_FFFF;
            end
            PASS_LOW: begin
                req.flow_tag = '0;
                req.source_address = '0;
                req.time_stamp = 64'sh8000_0000_0000_0000;
            end
            default: begin
                req.flow_tag = {$urandom, $urandom};
                req.source_address = $urandom;
                req.time_stamp = {$urandom, $urandom};
            end
        endcase
        pending_requests.push_back(req);
    endtask

    task automatic plan_byte(input int s, input logic [31:0] payload, input bit cont,
                             input bit ce);
        plan_hdr[s][plan_len[s]] = {cont, payload[6:0]};
        plan_ce[s][plan_len[s]] = ce;
        plan_len[s] = plan_len[s] + 1;
    endtask

    // Plans the next sequence on a slot: a well-formed frame most of the time,
    // otherwise a malformed prefix followed by discarded bytes up to a chunk end.
    task automatic plan_sequence(input int s);
        logic [31:0] value;
        logic [31:0] blen;
        int          n;
        int          k;
        int          junk;
        bit          ce_now;
        plan_len[s] = 0;
        plan_pos[s] = 0;
        plan_body[s] = 0;
        plan_cut[s] = 1'b0;
        if ($urandom_range(0, 99) < 80) begin
            k = $urandom_range(0, 99);
            if (k < 70) blen = $urandom_range(1, 12);
            else if (k < 92) blen = $urandom_range(13, 200);
            else blen = $urandom_range(201, MAX_LENGTH - vld_pkg::LENGTH_BIAS);
            value = blen + vld_pkg::LENGTH_BIAS;
            n = 1;
            while ((value >> (7 * n)) != 0) n++;
            // Some prefixes carry redundant zero groups up to the byte limit.
            if ($urandom_range(0, 4) == 0) n = $urandom_range(n, PREFIX_MAX);
            for (int i = 0; i < n; i++)
                plan_byte(s, value >> (7 * i), i < n - 1, $urandom_range(0, 7) == 0);
            if (blen > 60) begin
                plan_body[s] = $urandom_range(0, 8);
                plan_cut[s] = 1'b1;
            end else if ($urandom_range(0, 19) == 0) begin
                plan_body[s] = $urandom_range(0, blen - 1);
                plan_cut[s] = 1'b1;
            end else begin
                plan_body[s] = blen;
            end
        end else begin
            k = $urandom_range(0, 2);
            if (k == 0) begin
                // Length too small, optionally with a padding group.
                value = $urandom_range(0, vld_pkg::LENGTH_BIAS);
                n = $urandom_range(1, 2);
                for (int i = 0; i < n; i++) plan_byte(s, (i == 0) ? value : 0, i < n - 1, 0);
            end else begin
                for (int i = 0; i < 4; i++) plan_byte(s, $urandom_range(0, 127), 1, 0);
                // Either a fifth continuation byte or payload bits above bit 30.
                if (k == 1) plan_byte(s, $urandom_range(0, 7), 1, 0);
                else plan_byte(s, $urandom_range(8, 127), $urandom_range(0, 1), 0);
            end
            ce_now = $urandom_range(0, 1);
            plan_ce[s][plan_len[s] - 1] = ce_now;
            if (!ce_now) begin
                junk = $urandom_range(0, 3);
                for (int i = 0; i < junk; i++) plan_byte(s, $urandom, $urandom_range(0, 1), 0);
                plan_byte(s, $urandom, $urandom_range(0, 1), 1);
            end
        end
    endtask

    // Request driver: predicts on acceptance, then offers the next pending request.
    always @(posedge i_clk) begin : request_driver
        t_request next_req;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                deframe_request(offered_request);
                accepted_count++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    next_req = pending_requests.pop_front();
                    offered_request = next_req;
                    i_valid <= 1'b1;
                    i_command <= next_req.command;
                    i_flow_slot <= next_req.flow_slot;
                    i_flow_tag <= next_req.flow_tag;
                    i_source_address <= next_req.source_address;
                    i_time_stamp <= next_req.time_stamp;
                    i_data_byte <= next_req.data_byte;
                    i_chunk_end <= next_req.chunk_end;
                    send_gap = (((accepted_count / 250) % 4) == 3) ? 0 : idle_length();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            error_count++;
        end
    endtask

    // Result monitor: compares each accepted body byte with the prediction.
    always @(posedge i_clk) begin : result_monitor
        t_body_byte want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_bytes.size() == 0) begin
                $error("body byte %h arrived with nothing expected", o_body_byte);
                error_count++;
            end else begin
                want = expected_bytes.pop_front();
                check_field("out_flow_tag", want.flow_tag, o_out_flow_tag);
                check_field("out_source", want.source, o_out_source);
                check_field("out_time", want.time_stamp, o_out_time);
                check_field("body_byte", want.body_byte, o_body_byte);
                check_field("frame_length", want.frame_length, o_frame_length);
                check_field("first_of_frame", want.first_mark, o_first_of_frame);
                check_field("last_of_frame", want.last_mark, o_last_of_frame);
                check_field("malformed_total", want.malformed_total, o_malformed_total);
            end
            bytes_checked++;
            if (o_last_of_frame) frames_closed++;
        end
    end

    // Receiver stall, counted in cycles; one long hold-off lets the block fill up
    // and push back on the sender.
    always @(posedge i_clk) begin : receiver_stall
        int hold;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (!pressure_done && bytes_checked >= PRESSURE_AFTER) begin
                pressure_done = 1'b1;
                stall_left = PRESSURE_CYCLES - 1;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (((bytes_checked / 150) % 4) == 1) begin
                i_stall <= 1'b0;
            end else begin
                hold = idle_length();
                stall_left = (hold > 0) ? hold - 1 : 0;
                i_stall <= (hold > 0);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        int s;
        int waited;
        for (int i = 0; i < NSLOT; i++) begin
            clear_slot(i);
            plan_len[i] = 0;
            plan_pos[i] = 0;
            plan_body[i] = 0;
            plan_cut[i] = 1'b0;
        end

        // One-byte frame: first and last on the same byte, pass-through at its maximum.
        push_request(1'b0, 0, 8'h05, 1'b0, PASS_HIGH);
        push_request(1'b0, 0, 8'hFF, 1'b1, PASS_HIGH);
        // Redundant zero group in the prefix, then a two-byte body.
        push_request(1'b0, 1, 8'h86, 1'b0, PASS_RANDOM);
        push_request(1'b0, 1, 8'h00, 1'b1, PASS_RANDOM);
        push_request(1'b0, 1, 8'h00, 1'b0, PASS_LOW);
        push_request(1'b0, 1, 8'hA5, 1'b0, PASS_RANDOM);
        // Length too small on a chunk end, then mid-chunk with discard up to the chunk end.
        push_request(1'b0, 2, 8'h00, 1'b1, PASS_RANDOM);
        push_request(1'b0, 2, 8'h04, 1'b0, PASS_RANDOM);
        push_request(1'b0, 2, 8'h80, 1'b0, PASS_RANDOM);
        push_request(1'b0, 2, 8'h7F, 1'b1, PASS_RANDOM);
        // Prefix longer than the byte limit.
        for (int i = 0; i < 4; i++) push_request(1'b0, 3, 8'h80, 1'b0, PASS_RANDOM);
        push_request(1'b0, 3, 8'h80, 1'b1, PASS_RANDOM);
        // Prefix value beyond 31 bits.
        for (int i = 0; i < 4; i++) push_request(1'b0, 3, 8'hFF, 1'b0, PASS_RANDOM);
        push_request(1'b0, 3, 8'h08, 1'b1, PASS_RANDOM);
        // Largest legal length, one body byte, then a slot reset abandons the frame.
        for (int i = 0; i < 4; i++) push_request(1'b0, 0, 8'hFF, 1'b0, PASS_RANDOM);
        push_request(1'b0, 0, 8'h07, 1'b0, PASS_RANDOM);
        push_request(1'b0, 0, 8'h3C, 1'b0, PASS_LOW);
        push_request(1'b1, 0, 8'hFF, 1'b1, PASS_RANDOM);

        // Random part: interleaved per-slot sequences with occasional slot resets.
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            s = $urandom_range(0, NSLOT - 1);
            if ($urandom_range(0, 39) == 0) begin
                push_request(1'b1, s, $urandom, $urandom_range(0, 1), PASS_RANDOM);
                plan_pos[s] = plan_len[s];
                plan_body[s] = 0;
                plan_cut[s] = 1'b0;
            end else begin
                if (plan_pos[s] >= plan_len[s] && plan_body[s] == 0 && !plan_cut[s])
                    plan_sequence(s);
                if (plan_pos[s] < plan_len[s]) begin
                    push_request(1'b0, s, plan_hdr[s][plan_pos[s]], plan_ce[s][plan_pos[s]],
                                 PASS_RANDOM);
                    plan_pos[s] = plan_pos[s] + 1;
                end else if (plan_body[s] > 0) begin
                    push_request(1'b0, s, $urandom, $urandom_range(0, 9) == 0, PASS_RANDOM);
                    plan_body[s] = plan_body[s] - 1;
                end else begin
                    push_request(1'b1, s, $urandom, $urandom_range(0, 1), PASS_RANDOM);
                    plan_cut[s] = 1'b0;
                end
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to be taken, then for the results to drain.
        while (pending_requests.size() != 0 || i_valid) @(posedge i_clk);
        waited = 0;
        while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_bytes.size() != 0) begin
            $error("%0d expected body bytes never arrived", expected_bytes.size());
            error_count++;
        end

        $display("Run covered %0d requests on %0d flow slots: %0d body bytes checked,",
                 accepted_count, NSLOT, bytes_checked);
        $display("%0d frames closed and %0d malformed prefixes counted.",
                 frames_closed, malformed_seen);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
